### design/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro expands to one labeled concurrent assertion on a rising clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/pwdp_pkg.sv
// Package for the pulse-width distance front end: widths, codes, reset values,
// the lane structs and the scale-by-ten helper. No dependencies.
package pwdp_pkg;

  // Field and datapath widths.
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int OP_W        = 2;
  localparam int CNT_W       = 16;
  localparam int PERIOD_W    = 17;
  localparam int DIST_W      = 14;
  localparam int SCALED_W    = 18;
  localparam int PROD_W      = 33;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Divide by ten as multiply by a rounded-up reciprocal and shift.
  localparam int DIV_MUL_W   = 20;
  localparam int DIV_SHIFT   = 23;
  localparam int DIV_PROD_W  = SCALED_W + DIV_MUL_W;
  localparam logic [DIV_MUL_W-1:0] DIV10_MUL = 20'd838861;
  localparam logic [SCALED_W-1:0]  SCALE_STEP = 18'd10;

  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  // Event codes.
  localparam logic [OP_W-1:0] OP_OVERFLOW = 2'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_TIMER_PERIOD  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESENCE_HOLD = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SIGNAL_TIMEOUT = 3'd5;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 17'd65535;
  localparam logic [DIST_W-1:0]   DIST_RESET     = 14'd10000;
  localparam logic [DIST_W-1:0]   WIN_LOW_RESET  = 14'd1500;
  localparam logic [DIST_W-1:0]   WIN_HIGH_RESET = 14'd3000;
  localparam logic [CNT_W-1:0]    HOLD_RESET     = 16'd60;
  localparam logic [CNT_W-1:0]    TIMEOUT_RESET  = 16'd20;

  // Thresholds as seen by a lane; distances are held scaled by ten.
  typedef struct packed {
    logic [SCALED_W-1:0] low_lim;
    logic [SCALED_W-1:0] high_lim;
    logic [SCALED_W-1:0] max_scaled;
    logic [CNT_W-1:0]    hold_ticks;
    logic [CNT_W-1:0]    timeout_ticks;
  } lane_cfg_t;

  // Per-lane command for the current beat.
  typedef struct packed {
    logic                overflow;
    logic                capture;
    logic                check;
    logic [CNT_W-1:0]    capture_value;
    logic [SCALED_W-1:0] measured_dist;
  } lane_cmd_t;

  // Lane state seen by the shared datapath, and the status after this beat.
  typedef struct packed {
    logic                expect_falling;
    logic [CNT_W-1:0]    start_time;
    logic [CNT_W-1:0]    overflow_count;
    logic [SCALED_W-1:0] dist_next;
    logic                present_next;
  } lane_view_t;

  // Distance times ten, built from shifts.
  function automatic logic [SCALED_W-1:0] scale10(input logic [DIST_W-1:0] d);
    logic [SCALED_W-1:0] w;
    w = SCALED_W'(d);
    return (w << 3) + (w << 1);
  endfunction

endpackage

### design/pwdp_in_if.sv
// Event channel: valid/ready handshake with the event payload.
// Depends on pwdp_pkg for field widths.
interface pwdp_in_if;
  logic                        valid;
  logic                        ready;
  logic [pwdp_pkg::OP_W-1:0]   op;
  logic                        channel;
  logic [pwdp_pkg::CNT_W-1:0]  capture_value;

  modport source (output valid, op, channel, capture_value, input ready);
  modport sink (input valid, op, channel, capture_value, output ready);
endinterface

### design/pwdp_out_if.sv
// Result channel: valid/ready handshake with the status payload.
// Depends on pwdp_pkg for field widths.
interface pwdp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        out_channel;
  logic [pwdp_pkg::DIST_W-1:0] distance;
  logic                        present;
  logic                        measured;

  modport source (output valid, out_channel, distance, present, measured, input ready);
  modport sink (input valid, out_channel, distance, present, measured, output ready);
endinterface

### design/pulse_width_distance_presence.sv
// Pulse-width distance sensor front end with presence detection. It takes one
// event beat per cycle unless a stalled output holds evt.ready low, and returns
// one result beat per event, registered in the result stage and then the output
// stage. Each event's state update finishes in the cycle it is accepted, so
// the next event on the same channel sees it at once; the pulse width multiply
// and the window tests sit in that single cycle. Distances are kept internally
// scaled by ten, and the output stage divides by ten with a reciprocal multiply.
// Register writes take effect at the next clock edge; there is no clearing pass
// after reset. Depends on pwdp_pkg, pwdp_in_if, pwdp_out_if and pwdp_lane.
module pulse_width_distance_presence #(
  parameter int NUM_CHANNELS = pwdp_pkg::NUM_CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pwdp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pwdp_pkg::CFG_DATA_W-1:0]    cfg_data,
  pwdp_in_if.sink                            evt,
  pwdp_out_if.source                         res
);

  // Configuration registers, thresholds stored pre-scaled.
  logic [pwdp_pkg::PERIOD_W-1:0] timer_period;
  logic [pwdp_pkg::SCALED_W-1:0] max_limit;
  pwdp_pkg::lane_cfg_t           lane_cfg;
  logic [pwdp_pkg::SCALED_W-1:0] cfg_scaled;

  assign cfg_scaled = pwdp_pkg::scale10(cfg_data[pwdp_pkg::DIST_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_period           <= pwdp_pkg::PERIOD_RESET;
      lane_cfg.max_scaled    <= pwdp_pkg::scale10(pwdp_pkg::DIST_RESET);
      max_limit              <= pwdp_pkg::scale10(pwdp_pkg::DIST_RESET) + pwdp_pkg::SCALE_STEP;
      lane_cfg.low_lim       <= pwdp_pkg::scale10(pwdp_pkg::WIN_LOW_RESET)
                                + pwdp_pkg::SCALE_STEP;
      lane_cfg.high_lim      <= pwdp_pkg::scale10(pwdp_pkg::WIN_HIGH_RESET);
      lane_cfg.hold_ticks    <= pwdp_pkg::HOLD_RESET;
      lane_cfg.timeout_ticks <= pwdp_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pwdp_pkg::REG_TIMER_PERIOD: timer_period <= cfg_data;
        pwdp_pkg::REG_MAX_DISTANCE: begin
          lane_cfg.max_scaled <= cfg_scaled;
          max_limit           <= cfg_scaled + pwdp_pkg::SCALE_STEP;
        end
        pwdp_pkg::REG_WINDOW_LOW: lane_cfg.low_lim <= cfg_scaled + pwdp_pkg::SCALE_STEP;
        pwdp_pkg::REG_WINDOW_HIGH: lane_cfg.high_lim <= cfg_scaled;
        pwdp_pkg::REG_PRESENCE_HOLD:
          lane_cfg.hold_ticks <= cfg_data[pwdp_pkg::CNT_W-1:0];
        pwdp_pkg::REG_SIGNAL_TIMEOUT:
          lane_cfg.timeout_ticks <= cfg_data[pwdp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: a result stage and an output stage.
  logic s1_valid, s2_valid;
  logic out_free, s1_move, accept;

  assign out_free  = !s2_valid || res.ready;
  assign s1_move   = s1_valid && out_free;
  assign evt.ready = !s1_valid || out_free;
  assign accept    = evt.valid && evt.ready;

  // Channel lanes and selection of the addressed one.
  pwdp_pkg::lane_cmd_t  cmd  [NUM_CHANNELS];
  pwdp_pkg::lane_view_t view [NUM_CHANNELS];
  pwdp_pkg::lane_view_t sel_view;
  logic                 ch_valid;
  logic [pwdp_pkg::SCALED_W-1:0] measured_dist;

  assign ch_valid = int'(evt.channel) < NUM_CHANNELS;

  always_comb begin
    sel_view = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (int'(evt.channel) == i) begin
        sel_view = view[i];
      end
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
    always_comb begin
      cmd[g].overflow      = accept && (evt.op == pwdp_pkg::OP_OVERFLOW);
      cmd[g].capture       = accept && (evt.op == pwdp_pkg::OP_CAPTURE)
                             && (int'(evt.channel) == g);
      cmd[g].check         = accept && (evt.op == pwdp_pkg::OP_CHECK)
                             && (int'(evt.channel) == g);
      cmd[g].capture_value = evt.capture_value;
      cmd[g].measured_dist = measured_dist;
    end

    pwdp_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .cfg  (lane_cfg),
      .cmd  (cmd[g]),
      .view (view[g])
    );
  end

  // Pulse width to scaled distance: width*3, clamped at ten times the maximum.
  logic [pwdp_pkg::PROD_W-1:0] span, end_time, width;
  logic [pwdp_pkg::PERIOD_W-1:0] width_lo;
  logic [pwdp_pkg::SCALED_W:0]   width_x3;
  logic                          width_big;

  always_comb begin
    span      = pwdp_pkg::PROD_W'(sel_view.overflow_count)
                * pwdp_pkg::PROD_W'(timer_period);
    end_time  = span + pwdp_pkg::PROD_W'(evt.capture_value);
    width     = (end_time > pwdp_pkg::PROD_W'(sel_view.start_time))
                ? end_time - pwdp_pkg::PROD_W'(sel_view.start_time) : '0;
    width_big = |width[pwdp_pkg::PROD_W-1:pwdp_pkg::PERIOD_W];
    width_lo  = width[pwdp_pkg::PERIOD_W-1:0];
    width_x3  = (pwdp_pkg::SCALED_W+1)'(width_lo)
                + ((pwdp_pkg::SCALED_W+1)'(width_lo) << 1);
    if (width_big || (width_x3 >= (pwdp_pkg::SCALED_W+1)'(max_limit))) begin
      measured_dist = lane_cfg.max_scaled;
    end else begin
      measured_dist = width_x3[pwdp_pkg::SCALED_W-1:0];
    end
  end

  // Result stage payload.
  logic                          s1_channel, s1_present, s1_measured;
  logic [pwdp_pkg::SCALED_W-1:0] s1_dist;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_channel  <= evt.channel;
      s1_dist     <= ch_valid ? sel_view.dist_next : '0;
      s1_present  <= ch_valid && sel_view.present_next;
      s1_measured <= ch_valid && (evt.op == pwdp_pkg::OP_CAPTURE)
                     && sel_view.expect_falling;
    end
  end

  // Output stage: divide the scaled distance by ten.
  logic [pwdp_pkg::DIV_PROD_W-1:0] div_prod;
  logic                            s2_channel, s2_present, s2_measured;
  logic [pwdp_pkg::DIST_W-1:0]     s2_distance;

  assign div_prod = pwdp_pkg::DIV_PROD_W'(s1_dist) * pwdp_pkg::DIV_PROD_W'(pwdp_pkg::DIV10_MUL);

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_channel  <= s1_channel;
      s2_distance <= div_prod[pwdp_pkg::DIV_SHIFT +: pwdp_pkg::DIST_W];
      s2_present  <= s1_present;
      s2_measured <= s1_measured;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (res.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  assign res.valid       = s2_valid;
  assign res.out_channel = s2_channel;
  assign res.distance    = s2_distance;
  assign res.present     = s2_present;
  assign res.measured    = s2_measured;

endmodule

### design/pwdp_lane.sv
// One sensor channel: capture state, presence detector and no-signal watchdog.
// Depends on pwdp_pkg for widths and the lane structs.
module pwdp_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  pwdp_pkg::lane_cfg_t   cfg,
  input  pwdp_pkg::lane_cmd_t   cmd,
  output pwdp_pkg::lane_view_t  view
);

  logic                          expect_falling, expect_falling_next;
  logic [pwdp_pkg::CNT_W-1:0]    start_time, start_time_next;
  logic [pwdp_pkg::CNT_W-1:0]    overflow_count, overflow_count_next;
  logic [pwdp_pkg::SCALED_W-1:0] scaled_dist, scaled_dist_next;
  logic                          present, present_next;
  logic [pwdp_pkg::CNT_W-1:0]    presence_timer, presence_timer_next;
  logic [pwdp_pkg::CNT_W-1:0]    no_signal_timer, no_signal_timer_next;

  logic                       in_win;
  logic [pwdp_pkg::CNT_W-1:0] ptimer_inc, ptimer_step, nsig_inc;

  // Window test on the scaled distance, and the saturating timer steps.
  assign in_win = (scaled_dist >= cfg.low_lim) && (scaled_dist < cfg.high_lim);
  assign ptimer_inc = (presence_timer == pwdp_pkg::CNT_MAX) ? presence_timer
                      : presence_timer + pwdp_pkg::CNT_W'(1);
  assign ptimer_step = in_win ? '0 : ptimer_inc;
  assign nsig_inc = (no_signal_timer == pwdp_pkg::CNT_MAX) ? no_signal_timer
                    : no_signal_timer + pwdp_pkg::CNT_W'(1);

  // Next state for the events that address this lane; an overflow event reaches every lane.
  always_comb begin
    expect_falling_next  = expect_falling;
    start_time_next      = start_time;
    overflow_count_next  = overflow_count;
    scaled_dist_next     = scaled_dist;
    present_next         = present;
    presence_timer_next  = presence_timer;
    no_signal_timer_next = no_signal_timer;

    if (cmd.overflow) begin
      if (overflow_count != pwdp_pkg::CNT_MAX) begin
        overflow_count_next = overflow_count + pwdp_pkg::CNT_W'(1);
      end
    end

    if (cmd.capture) begin
      if (!expect_falling) begin
        start_time_next     = cmd.capture_value;
        overflow_count_next = '0;
        expect_falling_next = 1'b1;
      end else begin
        scaled_dist_next     = cmd.measured_dist;
        no_signal_timer_next = '0;
        expect_falling_next  = 1'b0;
      end
    end

    if (cmd.check) begin
      // Presence uses the distance from before the watchdog acts.
      if (present || in_win) begin
        if (ptimer_step >= cfg.hold_ticks) begin
          present_next        = 1'b0;
          presence_timer_next = '0;
        end else begin
          present_next        = 1'b1;
          presence_timer_next = ptimer_step;
        end
      end
      if (nsig_inc >= cfg.timeout_ticks) begin
        scaled_dist_next     = cfg.max_scaled;
        no_signal_timer_next = '0;
      end else begin
        no_signal_timer_next = nsig_inc;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_falling  <= 1'b0;
      start_time      <= '0;
      overflow_count  <= '0;
      scaled_dist     <= pwdp_pkg::scale10(pwdp_pkg::DIST_RESET);
      present         <= 1'b0;
      presence_timer  <= '0;
      no_signal_timer <= '0;
    end else begin
      expect_falling  <= expect_falling_next;
      start_time      <= start_time_next;
      overflow_count  <= overflow_count_next;
      scaled_dist     <= scaled_dist_next;
      present         <= present_next;
      presence_timer  <= presence_timer_next;
      no_signal_timer <= no_signal_timer_next;
    end
  end

  assign view.expect_falling = expect_falling;
  assign view.start_time     = start_time;
  assign view.overflow_count = overflow_count;
  assign view.dist_next      = scaled_dist_next;
  assign view.present_next   = present_next;

endmodule

### design/pwdp_checker.sv
// Port-level checker for the distance front end, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pwdp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        evt_valid,
  input logic                        evt_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic                        res_out_channel,
  input logic [pwdp_pkg::DIST_W-1:0] res_distance,
  input logic                        res_present,
  input logic                        res_measured
);

  // Beats accepted on the event side and not yet delivered.
  logic [1:0] pending;
  logic       in_beat, out_beat;

  assign in_beat  = evt_valid && evt_ready;
  assign out_beat = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(in_beat) - 2'(out_beat);
    end
  end

  `ASSERT_NXT_ALWAYS(a_reset_empties_output, clk, rst, !res_valid)
  `ASSERT_IMP(a_empty_output_takes_events, clk, rst, !res_valid, evt_ready)
  `ASSERT_IMP(a_result_has_event, clk, rst, res_valid, pending != 2'd0)
  `ASSERT_IMP(a_depth_bounded, clk, rst, 1'b1, pending != 2'd3)
  `ASSERT_NXT(a_stalled_result_holds, clk, rst, res_valid && !res_ready, res_valid && $stable(res_distance) && $stable(res_out_channel) && $stable(res_present) && $stable(res_measured))

endmodule

bind pulse_width_distance_presence pwdp_checker u_pwdp_checker (
  .clk             (clk),
  .rst             (rst),
  .evt_valid       (evt.valid),
  .evt_ready       (evt.ready),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_out_channel (res.out_channel),
  .res_distance    (res.distance),
  .res_present     (res.present),
  .res_measured    (res.measured)
);
